>>> rtl/core/msd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants for the motor stall detector
// Field widths, window sizing, the constant reciprocal used for the window
// average, and the structs passed between the window and the run controller.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int WINDOW_LEN = 20;
    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 14;
    localparam int THRESH_W   = 10;

    // Reset values of the configuration registers
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(415);
    localparam logic [TIME_W-1:0]   GRACE_RESET  = TIME_W'(300);

    // Running sum and slot sizing
    localparam int SUM_MAX = WINDOW_LEN * ((1 << SAMPLE_W) - 1);
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int SLOT_W  = $clog2(WINDOW_LEN);

    // Divide by WINDOW_LEN as multiply by a rounded-up reciprocal and shift.
    // With DIV_SH = SUM_W + clog2(WINDOW_LEN) the quotient is exact for every sum.
    localparam int    DIV_SH  = SUM_W + $clog2(WINDOW_LEN);
    localparam longint RECIP  = ((longint'(1) << DIV_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int    RECIP_W = $clog2(RECIP + 1);
    localparam int    PROD_W  = SUM_W + RECIP_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TIME_W;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE     = 1'b1;

    // Item kinds
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        DRIVE_RELEASE,
        DRIVE_FORWARD,
        DRIVE_BACKWARD
    } t_drive;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUNNING,
        ST_TIMEOUT,
        ST_STALL
    } t_status;

    typedef struct packed {
        logic                kind;
        logic [TIME_W-1:0]   max_time_ms;
        logic                direction;
        logic [1:0]          stall_level;
        logic [SAMPLE_W-1:0] sensor_sample;
        logic [TIME_W-1:0]   elapsed_ms;
    } t_item;

    // drive_command in the lowest bits
    typedef struct packed {
        t_status             run_status;
        logic [SAMPLE_W-1:0] window_average;
        t_drive              drive_command;
    } t_result;

    typedef struct packed {
        logic                clear;
        logic                push;
        logic [SAMPLE_W-1:0] sample;
    } t_win_cmd;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] sum_pushed;
    } t_win_view;

    function automatic logic [SAMPLE_W-1:0] avg_of(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(RECIP);
        return prod[DIV_SH +: SAMPLE_W];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/motor_stall_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_stall_detector_top: timed motor run with moving-average stall detection
// Start items arm a run; sample items feed a twenty-sample window whose
// average is compared against a threshold to count up a stall.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transfer when                Carries
//  -------   ---------  ---------------------------  ----------------------------
//  s (in)    slave      i_s_tvalid & o_s_tready      start or sensor sample item
//  m (out)   master     o_m_tvalid & i_m_tready      drive, window average, status
//  cfg       slave      i_cfg_valid & o_cfg_ready    register index and data
//
//  One item per cycle while the m side keeps taking results; each result
//  goes through the input register, then the result register.
//  The per-item path is the running-sum update followed by the constant
//  multiply for the divide by twenty and the stall compare.
//  A stall on the m side holds both stages and drops o_s_tready only when the
//  result register is full and not being taken.
//  Synchronous active-low reset empties both stages, clears the window and
//  loads threshold 415 and grace 300. Both ready outputs stay low during
//  reset; out of reset config is always ready.
//
module motor_stall_detector_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [13:0] max_time_ms, [14] direction, [16:15] stall_level,
    // [26:17] sensor_sample, [40:27] elapsed_ms, [47:41] zero
    input  wire logic [msd_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [0] kind
    input  wire logic                            i_s_tuser,
    // master stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [1:0] drive_command, [11:2] window_average, [13:12] run_status, [15:14] zero
    output logic [msd_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    // configuration write
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [msd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [msd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import msd_pkg::*;

    logic                r_in_valid;
    t_item               r_in_item;
    logic                r_out_valid;
    t_result             r_out;
    logic [THRESH_W-1:0] r_threshold;
    logic [TIME_W-1:0]   r_grace;

    logic                adv;
    logic                fire;
    t_item               in_item;
    t_result             result;
    t_win_cmd            win_cmd;
    t_win_view           win_view;

    // Advance the pipe whenever the result register is free or draining
    assign adv        = !r_out_valid || i_m_tready;
    assign fire       = adv && r_in_valid;
    assign o_s_tready = adv && i_rst_n;

    // Unpack the transfer
    assign in_item.kind          = i_s_tuser;
    assign in_item.max_time_ms   = i_s_tdata[13:0];
    assign in_item.direction     = i_s_tdata[14];
    assign in_item.stall_level   = i_s_tdata[16:15];
    assign in_item.sensor_sample = i_s_tdata[26:17];
    assign in_item.elapsed_ms    = i_s_tdata[40:27];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid  <= i_s_tvalid;
            r_out_valid <= r_in_valid;
        end
    end

    // Payload stages: hold while stalled
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_item <= in_item;
            r_out     <= result;
        end
    end

    // Configuration registers
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_grace     <= GRACE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_GRACE:     r_grace     <= i_cfg_data[TIME_W-1:0];
                default:       ;
            endcase
        end
    end

    msd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (win_cmd),
        .o_view  (win_view)
    );

    msd_run_ctrl u_run_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_threshold (r_threshold),
        .i_grace     (r_grace),
        .i_view      (win_view),
        .o_cmd       (win_cmd),
        .o_result    (result)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - $bits(t_result))'(0), r_out};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_m_tvalid)
        else $error("processed item did not reach the result register");

    a_stop_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_out.run_status != ST_RUNNING))
        |-> (r_out.drive_command == DRIVE_RELEASE))
        else $error("motor driven while run is not active");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    a_stalled_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input stage changed while stalled");

endmodule
`default_nettype wire

>>> rtl/core/msd_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_window: sample window with running sum
// Holds the last WINDOW_LEN samples in a ring, keeps their sum and offers
// the sum as it would stand after the next push.
// ----------------------------------------------------------------------------
module msd_window (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire msd_pkg::t_win_cmd i_cmd,
    output msd_pkg::t_win_view     o_view
);
    import msd_pkg::*;

    logic [SAMPLE_W-1:0] r_win [WINDOW_LEN];
    logic [SUM_W-1:0]    r_sum;
    logic [SLOT_W-1:0]   r_slot;
    logic [SUM_W-1:0]    n_sum;
    logic [SLOT_W-1:0]   n_slot;

    // Drop the oldest entry and add the new one
    assign n_sum = r_sum - SUM_W'(r_win[r_slot]) + SUM_W'(i_cmd.sample);
    assign n_slot = (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;

    assign o_view.sum        = r_sum;
    assign o_view.sum_pushed = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_sum  <= '0;
            r_slot <= '0;
        end else if (i_cmd.push) begin
            r_win[r_slot] <= i_cmd.sample;
            r_sum         <= n_sum;
            r_slot        <= n_slot;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/msd_run_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_run_ctrl: run state, timeout and stall counting
// Decodes one item against the run state, steers the window and forms the
// result item.
// ----------------------------------------------------------------------------
module msd_run_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire msd_pkg::t_item                i_item,
    input  wire logic [msd_pkg::THRESH_W-1:0]  i_threshold,
    input  wire logic [msd_pkg::TIME_W-1:0]    i_grace,
    input  wire msd_pkg::t_win_view            i_view,
    output msd_pkg::t_win_cmd                  o_cmd,
    output msd_pkg::t_result                   o_result
);
    import msd_pkg::*;

    logic              r_active;
    logic [1:0]        r_count;
    logic [1:0]        r_limit;
    logic [TIME_W-1:0] r_time_limit;
    logic              r_dir;

    logic              n_active;
    logic [1:0]        n_count;
    logic [1:0]        n_limit;
    logic [TIME_W-1:0] n_time_limit;
    logic              n_dir;

    logic              is_update;
    logic [SUM_W-1:0]  div_in;
    logic [SAMPLE_W-1:0] avg;
    t_win_cmd          cmd;

    assign is_update = (i_item.kind == KIND_SAMPLE) && r_active
                       && (i_item.elapsed_ms < r_time_limit);
    assign div_in    = is_update ? i_view.sum_pushed : i_view.sum;
    assign avg       = avg_of(div_in);

    always_comb begin
        n_active     = r_active;
        n_count      = r_count;
        n_limit      = r_limit;
        n_time_limit = r_time_limit;
        n_dir        = r_dir;
        cmd.clear    = 1'b0;
        cmd.push     = 1'b0;
        cmd.sample   = i_item.sensor_sample;
        o_result.drive_command  = DRIVE_RELEASE;
        o_result.window_average = avg;
        o_result.run_status     = ST_IDLE;

        if (i_item.kind == KIND_START) begin
            cmd.clear    = 1'b1;
            n_count      = '0;
            n_time_limit = i_item.max_time_ms;
            n_dir        = i_item.direction;
            case (i_item.stall_level)
                2'd2:    n_limit = 2'd2;
                2'd1:    n_limit = 2'd3;
                default: n_limit = 2'd1;
            endcase
            o_result.window_average = '0;
            if (i_item.max_time_ms == '0) begin
                n_active            = 1'b0;
                o_result.run_status = ST_TIMEOUT;
            end else begin
                n_active               = 1'b1;
                o_result.run_status    = ST_RUNNING;
                o_result.drive_command = i_item.direction ? DRIVE_FORWARD : DRIVE_BACKWARD;
            end
        end else if (!r_active) begin
            o_result.run_status = ST_IDLE;
        end else if (!is_update) begin
            // elapsed time reached the limit: stop before using the sample
            n_active            = 1'b0;
            o_result.run_status = ST_TIMEOUT;
        end else begin
            cmd.push = 1'b1;
            if ((avg <= i_threshold) && (i_item.elapsed_ms > i_grace)) begin
                if (r_count != 2'd3) begin
                    n_count = r_count + 2'd1;
                end
            end else if (r_count != 2'd0) begin
                n_count = r_count - 2'd1;
            end
            if (n_count >= r_limit) begin
                n_active            = 1'b0;
                o_result.run_status = ST_STALL;
            end else begin
                o_result.run_status    = ST_RUNNING;
                o_result.drive_command = r_dir ? DRIVE_FORWARD : DRIVE_BACKWARD;
            end
        end
    end

    // Window moves only when the item is really processed
    assign o_cmd.clear  = cmd.clear & i_fire;
    assign o_cmd.push   = cmd.push & i_fire;
    assign o_cmd.sample = cmd.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_count      <= '0;
            r_limit      <= 2'd1;
            r_time_limit <= '0;
            r_dir        <= 1'b0;
        end else if (i_fire) begin
            r_active     <= n_active;
            r_count      <= n_count;
            r_limit      <= n_limit;
            r_time_limit <= n_time_limit;
            r_dir        <= n_dir;
        end
    end

endmodule
`default_nettype wire
